// ===== rtl/brs_pkg.sv =====
// ----------------------------------------------------------------------------
// brs_pkg: shared types and constants for the bisection root sequencer
// Holds the request codes, configuration register indexes, the queue entry
// and response layouts, the search state enums and the fixed-point helpers.
// ----------------------------------------------------------------------------
package brs_pkg;

	localparam int unsigned Q_W         = 32;
	localparam int unsigned REQ_W       = 2;
	localparam int unsigned LIMIT_W     = 16;
	localparam int unsigned TOL_W       = 31;
	localparam int unsigned CFG_INDEX_W = 1;
	localparam int unsigned CFG_DATA_W  = 32;
	localparam int unsigned QUEUE_DEPTH = 2;

	// Request type codes carried on the request channel.
	localparam logic [REQ_W-1:0] REQ_BRACKET  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_ROOT     = 2'd1;
	localparam logic [REQ_W-1:0] REQ_VALUE    = 2'd2;
	localparam logic [REQ_W-1:0] REQ_RESERVED = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] CFG_IDX_LIMIT = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_IDX_TOL   = 1'b1;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd64;
	localparam logic [TOL_W-1:0]   TOL_RESET   = 31'd1;

	// One in Q16.16.
	localparam logic signed [Q_W:0] ONE_Q16 = 33'sd65536;

	typedef enum logic [1:0] {
		KIND_BRACKET,
		KIND_ROOT,
		KIND_VALUE
	} kind_t;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_BRACKET,
		MODE_ROOT
	} mode_t;

	typedef enum logic [1:0] {
		PQ_NONE,
		PQ_LOW,
		PQ_HIGH,
		PQ_MID
	} pq_t;

	typedef struct packed {
		kind_t                 kind;
		logic signed [Q_W-1:0] range_low;
		logic signed [Q_W-1:0] range_high;
		logic signed [Q_W-1:0] func_value;
	} item_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] iteration_limit;
		logic [TOL_W-1:0]   tolerance;
	} cfg_regs_t;

	typedef struct packed {
		logic                  is_final;
		logic signed [Q_W-1:0] query_point;
		logic                  found;
		logic signed [Q_W-1:0] bracket_low;
		logic signed [Q_W-1:0] bracket_high;
		logic signed [Q_W-1:0] root_estimate;
	} rsp_t;

	// Clamp a 33-bit signed value into the 32-bit signed range.
	function automatic logic signed [Q_W-1:0] sat33(input logic signed [Q_W:0] v);
		logic signed [Q_W-1:0] r;
		if (v[Q_W] != v[Q_W-1]) begin
			r = v[Q_W] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
		end else begin
			r = v[Q_W-1:0];
		end
		return r;
	endfunction

	// Exact midpoint of two ends, rounded toward zero.
	function automatic logic signed [Q_W-1:0] midpoint(input logic signed [Q_W-1:0] a,
		input logic signed [Q_W-1:0] b);
		logic signed [Q_W:0] sum;
		logic signed [Q_W:0] adj;
		sum = {a[Q_W-1], a} + {b[Q_W-1], b};
		adj = sum + {{Q_W{1'b0}}, sum[Q_W]};
		return adj[Q_W:1];
	endfunction

	// Two values bracket a root when either is zero or their signs differ.
	function automatic logic brackets(input logic signed [Q_W-1:0] a,
		input logic signed [Q_W-1:0] b);
		return (a == '0) || (b == '0) || (a[Q_W-1] != b[Q_W-1]);
	endfunction

endpackage

// ===== rtl/brs_req_if.sv =====
// ----------------------------------------------------------------------------
// brs_req_if: request channel
// Valid/ready channel that carries start items and function values.
// ----------------------------------------------------------------------------
interface brs_req_if;
	logic                                valid;
	logic                                ready;
	logic [brs_pkg::REQ_W-1:0]           req_type;
	logic signed [brs_pkg::Q_W-1:0]      range_low;
	logic signed [brs_pkg::Q_W-1:0]      range_high;
	logic signed [brs_pkg::Q_W-1:0]      func_value;

	modport source (output valid, output req_type, output range_low, output range_high,
		output func_value, input ready);
	modport sink (input valid, input req_type, input range_low, input range_high,
		input func_value, output ready);
endinterface

// ===== rtl/brs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// brs_rsp_if: response channel
// Valid/ready channel that carries query requests and final answers.
// ----------------------------------------------------------------------------
interface brs_rsp_if;
	logic                           valid;
	logic                           ready;
	logic                           is_final;
	logic signed [brs_pkg::Q_W-1:0] query_point;
	logic                           found;
	logic signed [brs_pkg::Q_W-1:0] bracket_low;
	logic signed [brs_pkg::Q_W-1:0] bracket_high;
	logic signed [brs_pkg::Q_W-1:0] root_estimate;

	modport source (output valid, output is_final, output query_point, output found,
		output bracket_low, output bracket_high, output root_estimate, input ready);
	modport sink (input valid, input is_final, input query_point, input found,
		input bracket_low, input bracket_high, input root_estimate, output ready);
endinterface

// ===== rtl/brs_cfg_if.sv =====
// ----------------------------------------------------------------------------
// brs_cfg_if: configuration write channel
// Valid/ready channel that carries a register index and write data.
// ----------------------------------------------------------------------------
interface brs_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [brs_pkg::CFG_INDEX_W-1:0]     index;
	logic [brs_pkg::CFG_DATA_W-1:0]      data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/bisection_root_sequencer_core.sv =====
// A request transfer writes the queue, and the search engine then carries the
// item into the response register once that register is empty or draining.
// Throughput: one request per cycle while the response side is not stalled.
// Reset: asynchronous, active low; empties the queue and response register,
// returns the search to idle and loads the limit with 64 and tolerance with 1.
// ----------------------------------------------------------------------------
// bisection_root_sequencer_core: bracket search and bisection sequencer
// Drives an external function evaluator in Q16.16 fixed point. Each start or
// function value transfer yields at most one response: the next point to
// evaluate or the final answer of the search.
// ----------------------------------------------------------------------------
module bisection_root_sequencer_core (
	input  logic       clk,
	input  logic       arst_n,
	brs_req_if.sink    req,
	brs_rsp_if.source  rsp,
	brs_cfg_if.sink    cfg
);
	import brs_pkg::*;

	// The intake classifies each request transfer and places it in a short
	// queue. Reserved request codes are accepted and dropped there, so they
	// never reach the search engine. Configuration writes land in the intake's
	// register file, which the search engine reads directly.
	logic      push_valid;
	logic      push_ready;
	item_t     push_item;
	logic      pop_valid;
	logic      pop_ready;
	item_t     pop_item;
	cfg_regs_t cfg_regs;

	brs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.cfg        (cfg),
		.push_valid (push_valid),
		.push_item  (push_item),
		.push_ready (push_ready),
		.cfg_regs   (cfg_regs)
	);

	// The queue lets the intake keep taking transfers while the response
	// register is held by a stalled consumer, and the other way round.
	brs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item),
		.pop_ready  (pop_ready)
	);

	// The search engine takes one queued item per cycle whenever its response
	// register is empty or being drained. Bracket mode widens the interval by
	// half its width on each side with saturation; root mode bisects and
	// keeps the midpoint whose value has the smallest magnitude. A value that
	// arrives with no query outstanding is consumed without a response.
	brs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_item  (pop_item),
		.pop_ready (pop_ready),
		.cfg_regs  (cfg_regs),
		.rsp       (rsp)
	);
endmodule

// ===== rtl/brs_front.sv =====
// ----------------------------------------------------------------------------
// brs_front: request intake and configuration registers
// Decodes the request type, drops reserved codes and pushes classified items
// into the queue. Also holds the configuration register file.
// ----------------------------------------------------------------------------
module brs_front (
	input  logic                clk,
	input  logic                arst_n,
	brs_req_if.sink             req,
	brs_cfg_if.sink             cfg,
	output logic                push_valid,
	output brs_pkg::item_t      push_item,
	input  logic                push_ready,
	output brs_pkg::cfg_regs_t  cfg_regs
);
	import brs_pkg::*;

	cfg_regs_t cfg_q;

	// A reserved code is taken and discarded without using a queue slot.
	assign req.ready  = push_ready;
	assign push_valid = req.valid && (req.req_type != REQ_RESERVED);

	always_comb begin
		push_item.range_low  = req.range_low;
		push_item.range_high = req.range_high;
		push_item.func_value = req.func_value;
		unique case (req.req_type)
			REQ_BRACKET: push_item.kind = KIND_BRACKET;
			REQ_ROOT:    push_item.kind = KIND_ROOT;
			REQ_VALUE:   push_item.kind = KIND_VALUE;
			default:     push_item.kind = KIND_VALUE;
		endcase
	end

	assign cfg.ready = 1'b1;
	assign cfg_regs  = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.iteration_limit <= LIMIT_RESET;
			cfg_q.tolerance       <= TOL_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_IDX_LIMIT: cfg_q.iteration_limit <= cfg.data[LIMIT_W-1:0];
				CFG_IDX_TOL:   cfg_q.tolerance       <= cfg.data[TOL_W-1:0];
				default:       cfg_q <= cfg_q;
			endcase
		end
	end
endmodule

// ===== rtl/brs_queue.sv =====
// ----------------------------------------------------------------------------
// brs_queue: short queue between intake and search engine
// Small register FIFO so that intake and search engine stall independently.
// ----------------------------------------------------------------------------
module brs_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	input  brs_pkg::item_t  push_item,
	output logic            push_ready,
	output logic            pop_valid,
	output brs_pkg::item_t  pop_item,
	input  logic            pop_ready
);
	import brs_pkg::*;

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

	item_t            store_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != (PTR_W + 1)'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = store_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

// ===== rtl/brs_back.sv =====
// ----------------------------------------------------------------------------
// brs_back: search engine and response register
// Holds the bracket or bisection state, carries out one queued item per
// cycle unless stalled and registers the resulting query or final answer.
// ----------------------------------------------------------------------------
module brs_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_valid,
	input  brs_pkg::item_t     pop_item,
	output logic               pop_ready,
	input  brs_pkg::cfg_regs_t cfg_regs,
	brs_rsp_if.source          rsp
);
	import brs_pkg::*;

	// Search state.
	mode_t                 mode_q,      mode_d;
	pq_t                   pq_q,        pq_d;
	logic signed [Q_W-1:0] low_q,       low_d;
	logic signed [Q_W-1:0] high_q,      high_d;
	logic signed [Q_W-1:0] vlow_q,      vlow_d;
	logic [LIMIT_W-1:0]    cnt_q,       cnt_d;
	logic signed [Q_W-1:0] best_pt_q,   best_pt_d;
	logic [Q_W-1:0]        best_mag_q,  best_mag_d;

	// Response register.
	logic out_valid_q;
	rsp_t out_q;
	rsp_t res;
	logic has_res;
	logic step;

	// Shared arithmetic.
	logic signed [Q_W-1:0] rl, rh, f;
	logic signed [Q_W:0]   start_sum;
	logic signed [Q_W-1:0] start_high;
	logic signed [Q_W:0]   width;
	logic [Q_W-1:0]        diff;
	logic signed [Q_W-1:0] exp_low, exp_high;
	logic signed [Q_W-1:0] mid, new_mid;
	logic signed [Q_W-1:0] bis_low, bis_high;
	logic [Q_W-1:0]        mag;
	logic [LIMIT_W-1:0]    cnt_inc;
	logic                  brk, better, tol_hit, lim_cur, lim_inc, lim_zero, active;

	assign rl = pop_item.range_low;
	assign rh = pop_item.range_high;
	assign f  = pop_item.func_value;

	assign start_sum  = {rl[Q_W-1], rl} + ONE_Q16;
	assign start_high = (rh <= rl) ? sat33(start_sum) : rh;

	assign width    = {high_q[Q_W-1], high_q} - {low_q[Q_W-1], low_q};
	assign diff     = width[Q_W] ? '0 : width[Q_W:1];
	assign exp_low  = sat33({low_q[Q_W-1], low_q} - {1'b0, diff});
	assign exp_high = sat33({high_q[Q_W-1], high_q} + {1'b0, diff});

	assign brk      = brackets(vlow_q, f);
	assign mid      = midpoint(low_q, high_q);
	assign bis_low  = brk ? low_q : mid;
	assign bis_high = brk ? mid : high_q;
	assign new_mid  = midpoint(bis_low, bis_high);
	assign mag      = f[Q_W-1] ? (~f + 1'b1) : f;
	assign better   = mag < best_mag_q;
	assign tol_hit  = mag <= {1'b0, cfg_regs.tolerance};

	assign cnt_inc  = cnt_q + 1'b1;
	assign lim_cur  = cnt_q >= cfg_regs.iteration_limit;
	assign lim_inc  = cnt_inc >= cfg_regs.iteration_limit;
	assign lim_zero = cfg_regs.iteration_limit == '0;
	assign active   = (mode_q != MODE_IDLE) && (pq_q != PQ_NONE);

	assign pop_ready = !out_valid_q || rsp.ready;
	assign step      = pop_valid && pop_ready;

	// Next state of the search.
	always_comb begin
		mode_d     = mode_q;
		pq_d       = pq_q;
		low_d      = low_q;
		high_d     = high_q;
		vlow_d     = vlow_q;
		cnt_d      = cnt_q;
		best_pt_d  = best_pt_q;
		best_mag_d = best_mag_q;
		unique case (pop_item.kind)
			KIND_BRACKET, KIND_ROOT: begin
				low_d      = rl;
				vlow_d     = '0;
				cnt_d      = '0;
				best_pt_d  = '0;
				best_mag_d = '1;
				pq_d       = PQ_LOW;
				if (pop_item.kind == KIND_BRACKET) begin
					high_d = start_high;
					mode_d = MODE_BRACKET;
					if (lim_zero) begin
						mode_d = MODE_IDLE;
						pq_d   = PQ_NONE;
					end
				end else begin
					high_d = rh;
					mode_d = MODE_ROOT;
				end
			end
			default: begin
				if (active) begin
					if (pq_q == PQ_LOW) begin
						vlow_d = f;
						pq_d   = PQ_HIGH;
					end else if (mode_q == MODE_BRACKET) begin
						if (brk) begin
							mode_d = MODE_IDLE;
							pq_d   = PQ_NONE;
						end else begin
							cnt_d  = cnt_inc;
							low_d  = exp_low;
							high_d = exp_high;
							if (lim_inc) begin
								mode_d = MODE_IDLE;
								pq_d   = PQ_NONE;
							end else begin
								pq_d = PQ_LOW;
							end
						end
					end else if (pq_q == PQ_HIGH) begin
						if (!brk || lim_cur) begin
							mode_d = MODE_IDLE;
							pq_d   = PQ_NONE;
						end else begin
							pq_d = PQ_MID;
						end
					end else begin
						low_d  = bis_low;
						high_d = bis_high;
						if (!brk) begin
							vlow_d = f;
						end
						cnt_d = cnt_inc;
						if (better) begin
							best_mag_d = mag;
							best_pt_d  = mid;
						end
						if ((better && tol_hit) || lim_inc) begin
							mode_d = MODE_IDLE;
							pq_d   = PQ_NONE;
						end
					end
				end
			end
		endcase
	end

	// Result of the item: a query request, a final answer or nothing.
	always_comb begin
		res     = '0;
		has_res = 1'b1;
		unique case (pop_item.kind)
			KIND_BRACKET: begin
				if (lim_zero) begin
					res.is_final     = 1'b1;
					res.bracket_low  = rl;
					res.bracket_high = start_high;
				end else begin
					res.query_point = rl;
				end
			end
			KIND_ROOT: res.query_point = rl;
			default: begin
				if (!active) begin
					has_res = 1'b0;
				end else if (pq_q == PQ_LOW) begin
					res.query_point = high_q;
				end else if (mode_q == MODE_BRACKET) begin
					if (brk) begin
						res.is_final     = 1'b1;
						res.found        = 1'b1;
						res.bracket_low  = low_q;
						res.bracket_high = high_q;
					end else if (lim_inc) begin
						res.is_final     = 1'b1;
						res.bracket_low  = exp_low;
						res.bracket_high = exp_high;
					end else begin
						res.query_point = exp_low;
					end
				end else if (pq_q == PQ_HIGH) begin
					if (!brk) begin
						res.is_final = 1'b1;
					end else if (lim_cur) begin
						res.is_final      = 1'b1;
						res.root_estimate = best_pt_q;
					end else begin
						res.query_point = mid;
					end
				end else begin
					if (better && tol_hit) begin
						res.is_final      = 1'b1;
						res.found         = 1'b1;
						res.root_estimate = mid;
					end else if (lim_inc) begin
						res.is_final      = 1'b1;
						res.root_estimate = better ? mid : best_pt_q;
					end else begin
						res.query_point = new_mid;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			pq_q        <= PQ_NONE;
			low_q       <= '0;
			high_q      <= '0;
			vlow_q      <= '0;
			cnt_q       <= '0;
			best_pt_q   <= '0;
			best_mag_q  <= '1;
			out_valid_q <= 1'b0;
		end else begin
			if (step) begin
				mode_q     <= mode_d;
				pq_q       <= pq_d;
				low_q      <= low_d;
				high_q     <= high_d;
				vlow_q     <= vlow_d;
				cnt_q      <= cnt_d;
				best_pt_q  <= best_pt_d;
				best_mag_q <= best_mag_d;
			end
			if (step && has_res) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && has_res) begin
			out_q <= res;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.is_final      = out_q.is_final;
	assign rsp.query_point   = out_q.query_point;
	assign rsp.found         = out_q.found;
	assign rsp.bracket_low   = out_q.bracket_low;
	assign rsp.bracket_high  = out_q.bracket_high;
	assign rsp.root_estimate = out_q.root_estimate;
endmodule

// ===== verif/bisection_root_sequencer_core_tb.sv =====
// ----------------------------------------------------------------------------
// bisection_root_sequencer_core_tb: self-checking bench for the root sequencer
// Plays the part of the function evaluator. Every value sent back is computed
// from the query point that the bench's own predictor expects. A scoreboard
// then checks each response field by field. Directed cases cover the empty
// interval, saturating expansion, the zero limit, unbracketed roots, stray
// values, the full-scale magnitude and a limit lowered in the middle of a
// search. Random searches of both kinds follow, with random register settings
// and random gaps on the request and response sides.
// ----------------------------------------------------------------------------
module bisection_root_sequencer_core_tb;

	import brs_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 8;
	localparam int REPORT_MAX     = 10;
	localparam int TARGET_RESULTS = 1400;

	localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;
	localparam logic signed [Q_W-1:0] Q_ONE = 32'sd65536;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	brs_req_if req_ch();
	brs_rsp_if rsp_ch();
	brs_cfg_if cfg_ch();

	bisection_root_sequencer_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------------
	// Predictor state. This is a private copy of the search state and the two
	// registers. It is advanced once for every request transfer and once for
	// every configuration transfer, in the order the block sees them.
	// ------------------------------------------------------------------------
	mode_t                 srch_mode    = MODE_IDLE;
	pq_t                   pend_query   = PQ_NONE;
	logic signed [Q_W-1:0] lo_end       = '0;
	logic signed [Q_W-1:0] hi_end       = '0;
	logic signed [Q_W-1:0] lo_value     = '0;
	int                    iter_count   = 0;
	logic signed [Q_W-1:0] best_point_q = '0;
	logic [Q_W-1:0]        best_mag     = '1;
	logic [LIMIT_W-1:0]    lim_reg      = LIMIT_RESET;
	logic [TOL_W-1:0]      tol_reg      = TOL_RESET;

	// Responses the block still owes, oldest first.
	rsp_t due_responses[$];

	// What the last request transfer caused. The stimulus uses it to know
	// which point the block asked about and whether a search is still open.
	bit                    last_has   = 1'b0;
	bit                    open_query = 1'b0;
	logic signed [Q_W-1:0] next_point = '0;

	// Shape of the function the bench evaluates for the current search.
	longint fn_root  = 0;
	int     fn_shift = 0;
	bit     fn_neg   = 1'b0;
	bit     fn_const = 1'b0;
	bit     fn_noise = 1'b0;
	logic signed [Q_W-1:0] fn_level = '0;

	// When set, the matching side runs without any gaps.
	bit req_calm = 1'b0;
	bit rsp_calm = 1'b0;
	int rsp_stall = 0;

	int mismatches    = 0;
	int checked       = 0;
	int result_items  = 0;
	int ignored_items = 0;
	int searches      = 0;
	int answers       = 0;
	int answers_found = 0;
	int reg_writes    = 0;
	int idle_cycles   = 0;

	function automatic logic signed [Q_W-1:0] clamp_q(input longint v);
		if (v > longint'(Q_MAX))
			return Q_MAX;
		if (v < longint'(Q_MIN))
			return Q_MIN;
		return v[Q_W-1:0];
	endfunction

	function automatic bit sign_change(input logic signed [Q_W-1:0] a,
		input logic signed [Q_W-1:0] b);
		return (a == 0) || (b == 0) || ((a < 0) != (b < 0));
	endfunction

	// Midpoint of the current ends, exact and rounded toward zero.
	function automatic logic signed [Q_W-1:0] mid_of();
		longint s;
		s = (longint'(lo_end) + longint'(hi_end)) / 2;
		return s[Q_W-1:0];
	endfunction

	function automatic void end_search();
		srch_mode  = MODE_IDLE;
		pend_query = PQ_NONE;
	endfunction

	// Advance the predictor by one request. Returns 1 and fills r when the
	// request causes a response.
	function automatic bit next_response(input logic [REQ_W-1:0] code,
		input logic signed [Q_W-1:0] lo_in, input logic signed [Q_W-1:0] hi_in,
		input logic signed [Q_W-1:0] fv, output rsp_t r);
		longint                half;
		logic signed [Q_W-1:0] mid;
		logic [Q_W-1:0]        mag;
		longint                neg_fv;
		r = '0;
		if (code == REQ_BRACKET || code == REQ_ROOT) begin
			// A start always aborts whatever search was running.
			lo_end       = lo_in;
			hi_end       = hi_in;
			lo_value     = '0;
			iter_count   = 0;
			best_point_q = '0;
			best_mag     = '1;
			if (code == REQ_BRACKET) begin
				if (hi_end <= lo_end)
					hi_end = clamp_q(longint'(lo_end) + longint'(ONE_Q16));
				if (lim_reg == 0) begin
					end_search();
					r.is_final     = 1'b1;
					r.bracket_low  = lo_end;
					r.bracket_high = hi_end;
					return 1'b1;
				end
				srch_mode = MODE_BRACKET;
			end else begin
				srch_mode = MODE_ROOT;
			end
			pend_query    = PQ_LOW;
			r.query_point = lo_end;
			return 1'b1;
		end
		if (code != REQ_VALUE || srch_mode == MODE_IDLE || pend_query == PQ_NONE)
			return 1'b0;

		if (pend_query == PQ_LOW) begin
			lo_value      = fv;
			pend_query    = PQ_HIGH;
			r.query_point = hi_end;
			return 1'b1;
		end

		if (srch_mode == MODE_BRACKET) begin
			if (sign_change(lo_value, fv)) begin
				end_search();
				r.is_final     = 1'b1;
				r.found        = 1'b1;
				r.bracket_low  = lo_end;
				r.bracket_high = hi_end;
				return 1'b1;
			end
			iter_count++;
			half = (longint'(hi_end) - longint'(lo_end)) / 2;
			if (half < 0)
				half = 0;
			lo_end = clamp_q(longint'(lo_end) - half);
			hi_end = clamp_q(longint'(hi_end) + half);
			if (iter_count >= int'(lim_reg)) begin
				end_search();
				r.is_final     = 1'b1;
				r.bracket_low  = lo_end;
				r.bracket_high = hi_end;
				return 1'b1;
			end
			pend_query    = PQ_LOW;
			r.query_point = lo_end;
			return 1'b1;
		end

		// Root mode: the first value at the high end only checks the bracket.
		if (pend_query == PQ_HIGH) begin
			if (!sign_change(lo_value, fv)) begin
				end_search();
				r.is_final = 1'b1;
				return 1'b1;
			end
		end else begin
			mid = mid_of();
			if (fv < 0) begin
				neg_fv = -longint'(fv);
				mag    = neg_fv[Q_W-1:0];
			end else begin
				mag = fv;
			end
			if (!sign_change(lo_value, fv)) begin
				lo_end   = mid;
				lo_value = fv;
			end else begin
				hi_end = mid;
			end
			iter_count++;
			if (mag < best_mag) begin
				best_mag     = mag;
				best_point_q = mid;
				if (best_mag <= {1'b0, tol_reg}) begin
					end_search();
					r.is_final      = 1'b1;
					r.found         = 1'b1;
					r.root_estimate = best_point_q;
					return 1'b1;
				end
			end
		end
		if (iter_count >= int'(lim_reg)) begin
			end_search();
			r.is_final      = 1'b1;
			r.root_estimate = best_point_q;
			return 1'b1;
		end
		pend_query    = PQ_MID;
		r.query_point = mid_of();
		return 1'b1;
	endfunction

	// Gap lengths: mostly none, often short, now and then a long one.
	function automatic int gap_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// The function the bench evaluates: a clamped line through fn_root, a
	// constant of one sign, or occasional random values as noise.
	function automatic logic signed [Q_W-1:0] probe_value(input logic signed [Q_W-1:0] x);
		longint d;
		if (fn_noise && $urandom_range(0, 99) < 25)
			return $urandom;
		if (fn_const)
			return fn_level;
		d = (longint'(x) - fn_root) >>> fn_shift;
		if (fn_neg)
			d = -d;
		return clamp_q(d);
	endfunction

	// One request transfer. It is entered and left at a falling edge. Valid
	// stays high on return, so back-to-back items follow without a gap. A
	// caller that does something else first lowers it.
	task automatic send_item(input logic [REQ_W-1:0] code,
		input logic signed [Q_W-1:0] lo_in, input logic signed [Q_W-1:0] hi_in,
		input logic signed [Q_W-1:0] fv);
		int   gap;
		rsp_t r;
		gap = req_calm ? 0 : gap_cycles();
		if (gap > 0) begin
			req_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid      = 1'b1;
		req_ch.req_type   = code;
		req_ch.range_low  = lo_in;
		req_ch.range_high = hi_in;
		req_ch.func_value = fv;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		last_has = next_response(code, lo_in, hi_in, fv, r);
		if (last_has) begin
			due_responses.push_back(r);
			result_items++;
			open_query = !r.is_final;
			next_point = r.query_point;
			if (r.is_final) begin
				answers++;
				if (r.found)
					answers_found++;
			end
		end else begin
			ignored_items++;
		end
		@(negedge clk);
	endtask

	task automatic send_value(input logic signed [Q_W-1:0] fv);
		send_item(REQ_VALUE, $urandom, $urandom, fv);
	endtask

	// Register write. It happens only after every owed response has come
	// back and the settle time has passed, so no request is still in flight.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		req_ch.valid = 1'b0;
		while (due_responses.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data  = data;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		if (idx == CFG_IDX_LIMIT)
			lim_reg = data[LIMIT_W-1:0];
		else
			tol_reg = data[TOL_W-1:0];
		reg_writes++;
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Directed cases
	// ------------------------------------------------------------------------

	// Bracket start with high equal to low gets a high end one unit above.
	// With low at full scale, that step saturates and high equals low.
	task automatic test_empty_interval();
		send_item(REQ_BRACKET, 2 * Q_ONE, 2 * Q_ONE, 0);
		send_item(REQ_BRACKET, Q_MAX, 0, 0);
		send_value(7);
	endtask

	// The full range is expanded with the widest possible half width. Both
	// ends clamp, and the search gives up at the limit. The start also aborts
	// the search that was left open above.
	task automatic test_saturating_expansion();
		write_reg(CFG_IDX_LIMIT, 32'd2);
		send_item(REQ_BRACKET, Q_MIN, Q_MAX, 0);
		repeat (4) send_value(-5);
	endtask

	// With a zero limit, bracket mode answers at once. Root mode answers
	// once the bracket check has passed.
	task automatic test_zero_limit();
		write_reg(CFG_IDX_LIMIT, 32'd0);
		send_item(REQ_BRACKET, -Q_ONE, Q_ONE, 0);
		send_item(REQ_ROOT, -Q_ONE, Q_ONE, 0);
		send_value(-1);
		send_value(1);
	endtask

	// End values of the same sign stop a root search with nothing found.
	task automatic test_unbracketed_root();
		write_reg(CFG_IDX_LIMIT, 32'(LIMIT_RESET));
		send_item(REQ_ROOT, Q_ONE, 2 * Q_ONE, 0);
		send_value(3);
		send_value(7);
	endtask

	// A value with no query outstanding and the reserved code are dropped.
	task automatic test_stray_items();
		send_value(12345);
		send_item(REQ_RESERVED, $urandom, $urandom, $urandom);
	endtask

	// The most negative value has magnitude 2^31, above the widest tolerance.
	// The next midpoint is within it. Bit 31 of the tolerance write must be
	// dropped.
	task automatic test_extreme_magnitude();
		write_reg(CFG_IDX_TOL, 32'hFFFF_FFFF);
		send_item(REQ_ROOT, -Q_ONE, Q_ONE, 0);
		send_value(Q_MIN);
		send_value(Q_MAX);
		send_value(Q_MIN);
		send_value(32'sh8000_0001);
	endtask

	// The limit is lowered below the iteration count while a bisection is
	// open. The next value must end the search with the best point so far.
	task automatic test_limit_lowered();
		write_reg(CFG_IDX_TOL, 32'd0);
		send_item(REQ_ROOT, -8 * Q_ONE, 8 * Q_ONE, 0);
		send_value(-1);
		send_value(1);
		send_value(5);
		send_value(5);
		write_reg(CFG_IDX_LIMIT, 32'd1);
		send_value(3);
	endtask

	// ------------------------------------------------------------------------
	// Random part
	// ------------------------------------------------------------------------

	task automatic random_config();
		int                    r;
		logic [CFG_DATA_W-1:0] data;
		r = $urandom_range(0, 99);
		if ($urandom_range(0, 1)) begin
			if (r < 45)
				data = $urandom_range(1, 6);
			else if (r < 75)
				data = $urandom_range(7, 40);
			else if (r < 85)
				data = 32'(LIMIT_RESET);
			else if (r < 92)
				data = 32'hFFFF;
			else
				data = $urandom_range(1, 65535);
			// Bits above the register width carry junk and must be ignored.
			data[31:16] = 16'($urandom);
			write_reg(CFG_IDX_LIMIT, data);
		end else begin
			if (r < 20)
				data = 0;
			else if (r < 35)
				data = 1;
			else if (r < 70)
				data = $urandom_range(0, 65535);
			else if (r < 85)
				data = $urandom_range(0, 32'h7FFF_FFFF);
			else
				data = 32'h7FFF_FFFF;
			data[31] = 1'($urandom_range(0, 1));
			write_reg(CFG_IDX_TOL, data);
		end
	endtask

	// One search with a random interval and a random function. The bench
	// answers the block's queries until the search ends or it gives up
	// early; in that case the next start aborts the search.
	task automatic run_search();
		bit     root_mode;
		int     r;
		int     base;
		int     cap;
		int     n;
		longint span;
		logic signed [Q_W-1:0] lo;
		logic signed [Q_W-1:0] hi;
		root_mode = $urandom_range(0, 99) < 60;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			// Moderate interval, low end within +/-50.0, sometimes empty or reversed.
			base = int'($urandom_range(0, 6553600)) - 3276800;
			lo   = base;
			if ($urandom_range(0, 9) == 0)
				hi = lo - int'($urandom_range(0, 65536));
			else
				hi = lo + int'($urandom_range(1, 1310720));
		end else if (r < 85) begin
			base = int'($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000;
			lo   = base;
			hi   = lo + int'($urandom_range(1, 32'h2000_0000));
		end else begin
			lo = $urandom;
			hi = $urandom;
		end

		// The root lies anywhere from one width below to two widths above the
		// low end. When it is outside, bracket mode has to expand.
		span     = longint'(hi) - longint'(lo);
		fn_root  = longint'(lo) + span * (longint'($urandom_range(0, 300)) - 100) / 100;
		fn_shift = $urandom_range(0, 12);
		fn_neg   = 1'($urandom_range(0, 1));
		fn_const = $urandom_range(0, 99) < 15;
		fn_noise = $urandom_range(0, 99) < 10;
		fn_level = $urandom_range(1, 32'h7FFF_FFFF);
		if ($urandom_range(0, 1))
			fn_level = -fn_level;

		send_item(root_mode ? REQ_ROOT : REQ_BRACKET, lo, hi, $urandom);
		searches++;
		cap = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 5) : 70;
		n = 0;
		while (open_query && n < cap) begin
			if ($urandom_range(0, 49) == 0)
				send_item(REQ_RESERVED, $urandom, $urandom, $urandom);
			else
				send_value(probe_value(next_point));
			n++;
		end
	endtask

	task automatic test_random_searches();
		int r;
		while (result_items + ignored_items < TARGET_RESULTS) begin
			// Switch the no-gap stretches on and off from time to time.
			if ($urandom_range(0, 9) == 0)
				req_calm = !req_calm;
			if ($urandom_range(0, 9) == 0)
				rsp_calm = !rsp_calm;
			r = $urandom_range(0, 99);
			if (r < 6)
				random_config();
			else if (r < 12)
				send_item(REQ_W'($urandom_range(0, 3)), $urandom, $urandom, $urandom);
			else
				run_search();
		end
		req_calm = 1'b0;
		rsp_calm = 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Response side: random backpressure, driven at the falling edge.
	// ------------------------------------------------------------------------
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rsp_stall > 0) begin
				rsp_ch.ready = 1'b0;
				rsp_stall--;
			end else begin
				rsp_ch.ready = 1'b1;
				if (!rsp_calm)
					rsp_stall = gap_cycles();
			end
		end
	end

	// ------------------------------------------------------------------------
	// Scoreboard. It is sampled at the rising edge. Every response transfer is
	// checked field by field against the oldest owed response.
	// ------------------------------------------------------------------------
	task automatic check_field(input string name, input logic [Q_W-1:0] want,
		input logic [Q_W-1:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= REPORT_MAX)
				$display("Mismatch on %s: expected %h, got %h (response %0d)",
					name, want, got, checked);
		end
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (due_responses.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("Response transfer with none owed: final=%b query=%h",
						rsp_ch.is_final, rsp_ch.query_point);
			end else begin
				want = due_responses.pop_front();
				check_field("is_final", 32'(want.is_final), 32'(rsp_ch.is_final));
				check_field("query_point", want.query_point, rsp_ch.query_point);
				check_field("found", 32'(want.found), 32'(rsp_ch.found));
				check_field("bracket_low", want.bracket_low, rsp_ch.bracket_low);
				check_field("bracket_high", want.bracket_high, rsp_ch.bracket_high);
				check_field("root_estimate", want.root_estimate, rsp_ch.root_estimate);
				checked++;
			end
		end
	end

	// Watchdog: the run ends if no transfer happens on any channel for too long.
	initial begin
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Watchdog: no transfer for %0d cycles, %0d responses still owed",
			WATCHDOG_LIMIT, due_responses.size());
		$display("FAILED: results differ");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		req_ch.valid      = 1'b0;
		req_ch.req_type   = REQ_VALUE;
		req_ch.range_low  = '0;
		req_ch.range_high = '0;
		req_ch.func_value = '0;
		cfg_ch.valid      = 1'b0;
		cfg_ch.index      = CFG_IDX_LIMIT;
		cfg_ch.data       = '0;

		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_interval();
		test_saturating_expansion();
		test_zero_limit();
		test_unbracketed_root();
		test_stray_items();
		test_extreme_magnitude();
		test_limit_lowered();
		test_random_searches();

		// Let every owed response come back, then give the block time to show
		// anything it should not.
		req_ch.valid = 1'b0;
		while (due_responses.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Ran %0d searches: %0d ended with an answer, %0d found a bracket or root; %0d register writes.",
			searches, answers, answers_found, reg_writes);
		$display("%0d request transfers gave a response, %0d were ignored; %0d responses checked.",
			result_items, ignored_items, checked);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
